@@ rtl/core/qlat_pkg.sv @@
// Shared types and constants for the Q-learning action table.
// Request payloads, controller commands/status, state and code enums.
// No dependencies.
package qlat_pkg;

  // Field widths fixed by the request format
  localparam int unsigned BucketW = 4;
  localparam int unsigned RewardW = 8;
  localparam int unsigned DrawW   = 7;
  localparam int unsigned QW      = 32;
  localparam int unsigned RateW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Default largest health bucket
  localparam int unsigned BucketMaxDefault = 10;

  // Configuration reset values
  localparam logic [RateW-1:0] LearningRateRst     = 16'd6554;
  localparam logic [RateW-1:0] DiscountRst         = 16'd58982;
  localparam logic [DrawW-1:0] ExploreThresholdRst = 7'd10;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEARNING_RATE     = 2'd0,
    CFG_DISCOUNT          = 2'd1,
    CFG_EXPLORE_THRESHOLD = 2'd2
  } qlat_cfg_idx_e;

  // Request operations
  typedef enum logic {
    OP_CHOOSE = 1'b0,
    OP_UPDATE = 1'b1
  } qlat_op_e;

  // Input request
  typedef struct packed {
    logic                      op;
    logic [BucketW-1:0]        player_hp_bucket;
    logic [BucketW-1:0]        agent_hp_bucket;
    logic                      action_taken;
    logic [BucketW-1:0]        next_player_hp_bucket;
    logic [BucketW-1:0]        next_agent_hp_bucket;
    logic signed [RewardW-1:0] reward;
    logic [DrawW-1:0]          explore_draw;
    logic                      random_action;
  } qlat_in_t;

  // Result
  typedef struct packed {
    logic                 chosen_action;
    logic                 explored;
    logic signed [QW-1:0] q_value;
  } qlat_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NEXT,
    ST_RD_CUR,
    ST_FUTURE,
    ST_DELTA,
    ST_STEP,
    ST_WRITE,
    ST_CHOOSE
  } qlat_state_e;

  // Controller to datapath
  typedef struct packed {
    logic ld_item;
    logic rd_en;
    logic rd_next;
    logic ld_max;
    logic ld_future;
    logic ld_delta;
    logic ld_step;
    logic wr_en;
    logic ld_out;
  } qlat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_update;
    logic item_is_update;
  } qlat_status_t;

endpackage

@@ rtl/core/qlat_dp.sv @@
// Datapath of the Q-learning action table: request register, config
// registers, the two action tables with valid bits, update arithmetic, result.
// Depends on qlat_pkg.
module qlat_dp #(
  parameter int unsigned BUCKET_MAX = qlat_pkg::BucketMaxDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qlat_pkg::qlat_in_t           in_item_i,
  input  logic                         cfg_we_i,
  input  logic [qlat_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [qlat_pkg::CfgW-1:0]    cfg_data_i,
  input  qlat_pkg::qlat_cmd_t          cmd_i,
  output qlat_pkg::qlat_status_t       status_o,
  output qlat_pkg::qlat_out_t          out_item_o
);
  import qlat_pkg::*;

  localparam int unsigned Side  = BUCKET_MAX + 1;
  localparam int unsigned Rows  = Side * Side;
  localparam int unsigned RowW  = $clog2(Rows);
  localparam logic [BucketW-1:0] BMax = BucketW'(BUCKET_MAX);

  // Saturate a bucket to the largest one
  function automatic logic [BucketW-1:0] clamp_bucket(input logic [BucketW-1:0] b);
    clamp_bucket = (b > BMax) ? BMax : b;
  endfunction

  // Row of a state pair
  function automatic logic [RowW-1:0] row_of(input logic [BucketW-1:0] p,
                                             input logic [BucketW-1:0] a);
    row_of = RowW'(32'(clamp_bucket(p)) * Side + 32'(clamp_bucket(a)));
  endfunction

  qlat_in_t item_q;

  logic [RateW-1:0] learning_rate_q;
  logic [RateW-1:0] discount_q;
  logic [DrawW-1:0] explore_threshold_q;

  // Tables, one per action, indexed by state row
  logic signed [QW-1:0] mem0 [Rows];
  logic signed [QW-1:0] mem1 [Rows];
  logic [Rows-1:0]      valid0_q;
  logic [Rows-1:0]      valid1_q;

  logic signed [QW-1:0] rd0_q, rd1_q;
  logic                 rdv0_q, rdv1_q;
  logic signed [QW-1:0] q0, q1;

  logic [RowW-1:0] row;

  logic signed [QW-1:0] maxq_q;
  logic signed [QW-1:0] cur_q;
  logic signed [QW-1:0] fut_q;
  logic signed [33:0]   delta_q;
  logic signed [33:0]   step_q;
  logic signed [48:0]   fut_prod;
  logic signed [50:0]   step_prod;
  logic signed [33:0]   delta_d;
  logic signed [34:0]   sum;
  logic signed [QW-1:0] nv;

  logic      greedy;
  logic      explore;
  qlat_out_t out_q;
  qlat_out_t out_d;

  // Status
  assign status_o.in_is_update   = (in_item_i.op == OP_UPDATE);
  assign status_o.item_is_update = (item_q.op == OP_UPDATE);

  // Request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      item_q <= in_item_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learning_rate_q     <= LearningRateRst;
      discount_q          <= DiscountRst;
      explore_threshold_q <= ExploreThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEARNING_RATE:     learning_rate_q     <= cfg_data_i[RateW-1:0];
        CFG_DISCOUNT:          discount_q          <= cfg_data_i[RateW-1:0];
        CFG_EXPLORE_THRESHOLD: explore_threshold_q <= cfg_data_i[DrawW-1:0];
        default: ;
      endcase
    end
  end

  // Table address: next state or current state
  assign row = cmd_i.rd_next
             ? row_of(item_q.next_player_hp_bucket, item_q.next_agent_hp_bucket)
             : row_of(item_q.player_hp_bucket, item_q.agent_hp_bucket);

  // Table storage, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !item_q.action_taken) begin
      mem0[row] <= nv;
    end
    if (cmd_i.wr_en && item_q.action_taken) begin
      mem1[row] <= nv;
    end
    if (cmd_i.rd_en) begin
      rd0_q <= mem0[row];
      rd1_q <= mem1[row];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= '0;
      valid1_q <= '0;
      rdv0_q   <= 1'b0;
      rdv1_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_en && !item_q.action_taken) begin
        valid0_q[row] <= 1'b1;
      end
      if (cmd_i.wr_en && item_q.action_taken) begin
        valid1_q[row] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rdv0_q <= valid0_q[row];
        rdv1_q <= valid1_q[row];
      end
    end
  end

  assign q0 = rdv0_q ? rd0_q : '0;
  assign q1 = rdv1_q ? rd1_q : '0;

  // Update arithmetic, one multiply per stage
  assign fut_prod  = $signed({1'b0, discount_q}) * maxq_q;
  assign delta_d   = ($signed({{10{item_q.reward[RewardW-1]}}, item_q.reward, 16'b0}))
                   + 34'(fut_q) - 34'(cur_q);
  assign step_prod = $signed({1'b0, learning_rate_q}) * delta_q;
  assign sum       = 35'(cur_q) + 35'(step_q);

  // Saturate to the signed 32-bit range
  always_comb begin
    if (sum > 35'sd2147483647) begin
      nv = 32'sh7fffffff;
    end else if (sum < -35'sd2147483648) begin
      nv = 32'sh80000000;
    end else begin
      nv = sum[QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_max) begin
      maxq_q <= (q0 >= q1) ? q0 : q1;
    end
    if (cmd_i.ld_future) begin
      cur_q <= item_q.action_taken ? q1 : q0;
      fut_q <= fut_prod[47:16];
    end
    if (cmd_i.ld_delta) begin
      delta_q <= delta_d;
    end
    if (cmd_i.ld_step) begin
      step_q <= step_prod[49:16];
    end
  end

  // Result: greedy/explore choice or stored value
  assign greedy  = (q0 >= q1) ? 1'b0 : 1'b1;
  assign explore = (item_q.explore_draw < explore_threshold_q);

  always_comb begin
    if (item_q.op == OP_UPDATE) begin
      out_d.chosen_action = 1'b0;
      out_d.explored      = 1'b0;
      out_d.q_value       = nv;
    end else begin
      out_d.chosen_action = explore ? item_q.random_action : greedy;
      out_d.explored      = explore;
      out_d.q_value       = greedy ? q1 : q0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

@@ rtl/core/qlat_ctrl.sv @@
// Controller of the Q-learning action table: sequences table reads, the
// update stages and the write, and owns the request handshakes.
// Depends on qlat_pkg.
module qlat_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  qlat_pkg::qlat_status_t status_i,
  output qlat_pkg::qlat_cmd_t    cmd_o
);
  import qlat_pkg::*;

  qlat_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d = status_i.in_is_update ? ST_RD_NEXT : ST_RD_CUR;
        end
      end
      ST_RD_NEXT: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = ST_RD_CUR;
      end
      ST_RD_CUR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.ld_max = 1'b1;
        state_d      = status_i.item_is_update ? ST_FUTURE : ST_CHOOSE;
      end
      ST_FUTURE: begin
        cmd_o.ld_future = 1'b1;
        state_d         = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o.ld_delta = 1'b1;
        state_d        = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.ld_step = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_CHOOSE: begin
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result slot: set on load, cleared when taken
  always_comb begin
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  // Update sequence runs RD_NEXT, RD_CUR, FUTURE, DELTA, STEP, then WRITE
  a_update_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_NEXT) |-> ##5 (state_q == ST_WRITE))
    else $error("update sequence broken");

  // Table is written only on an update whose result is being loaded
  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (cmd_o.ld_out && status_i.item_is_update))
    else $error("table write without update result");

endmodule

@@ rtl/core/q_learning_action_table_core.sv @@
// Tabular Q-learning action table with epsilon-greedy choice. A choose request
// reads the current state's pair, then loads its result; an update request
// reads the next state's pair, then the current state's pair, runs the gamma
// and alpha multiplies in separate stages and writes back with its result.
// Either waits while a result is still pending, and the block takes the next
// request only after the result is loaded. This sequencing comes from the one
// address port of the table and the single-request controller. The table is
// zero after reset through per-entry valid bits; no clearing pass is needed.
// Depends on qlat_pkg, qlat_ctrl and qlat_dp.
module q_learning_action_table_core #(
  parameter int unsigned BUCKET_MAX = qlat_pkg::BucketMaxDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qlat_pkg::qlat_in_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output qlat_pkg::qlat_out_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [qlat_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [qlat_pkg::CfgW-1:0]    cfg_data_i
);
  import qlat_pkg::*;

  qlat_cmd_t    cmd;
  qlat_status_t status;

  // Sequencer
  qlat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tables and arithmetic
  qlat_dp #(
    .BUCKET_MAX (BUCKET_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
